@@ design/sobel_edge_threshold_top_assert.svh @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: assertion macros
// Shared macros for the concurrent checks of the edge detector.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_THRESHOLD_TOP_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SOBEL_ET_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SOBEL_ET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sobel_et_pkg.sv @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: package
// Sizes, register indexes, shared types and helpers of the edge detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sobel_et_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Field widths
  localparam int PIX_W  = 8;
  localparam int DIM_W  = 11;
  localparam int POS_W  = 10;
  localparam int GRAD_W = PIX_W + 3;
  localparam int SQ_W   = 2 * GRAD_W - 2;
  localparam int MAG_W  = SQ_W + 1;

  // Edge when gx^2 + gy^2 exceeds (50 * 4)^2
  localparam int EDGE_LIMIT_SQ = 40000;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // One window column: three vertically adjacent pixels
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

  // Position tag that travels with a result
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             last;
  } pos_t;

  // Clamp a frame dimension into [3, maxv]
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(3)) begin
      res = DIM_W'(3);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/sobel_et_pix_if.sv @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: pixel channel
// Valid/ready channel that carries one gray pixel per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sobel_et_pix_if
  import sobel_et_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

@@ design/sobel_et_res_if.sv @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: result channel
// Valid/ready channel that carries one edge flag with its position.
// ----------------------------------------------------------------------------
`default_nettype none

interface sobel_et_res_if
  import sobel_et_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             edge_res;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] column;
  logic             last;

  modport source (output valid, output edge_res, output row, output column,
                  output last, input ready);
  modport sink   (input valid, input edge_res, input row, input column,
                  input last, output ready);
endinterface

`default_nettype wire

@@ design/sobel_et_win_cell.sv @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: window cell
// Holds one column of the 3x3 window and hands it to its neighbor on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_et_win_cell
  import sobel_et_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     clr_i,
  input  wire logic     shift_i,
  input  wire pix_col_t col_i,
  output pix_col_t      col_o
);

  pix_col_t col_q, col_d;

  // Drop the column on frame restart, take the neighbor's column on shift
  always_comb begin
    col_d = col_q;
    if (clr_i) begin
      col_d = '0;
    end else if (shift_i) begin
      col_d = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

@@ design/sobel_et_line_store.sv @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: line store
// Two row memories, one read port and one write port each, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_et_line_store
  import sobel_et_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [COL_W-1:0] rd_addr_i,
  output logic      [PIX_W-1:0] rd_up_o,
  output logic      [PIX_W-1:0] rd_mid_o,
  input  wire logic             wr_en_i,
  input  wire logic [COL_W-1:0] wr_addr_i,
  input  wire logic [PIX_W-1:0] wr_up_i,
  input  wire logic [PIX_W-1:0] wr_mid_i
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_up_q;
  logic [PIX_W-1:0] rd_mid_q;

  // Read the two rows above the incoming pixel
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_up_q  <= upper_mem[rd_addr_i];
      rd_mid_q <= middle_mem[rd_addr_i];
    end
  end

  // Move the middle row up and store the new pixel as the middle row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= wr_up_i;
      middle_mem[wr_addr_i] <= wr_mid_i;
    end
  end

  assign rd_up_o  = rd_up_q;
  assign rd_mid_o = rd_mid_q;

endmodule

`default_nettype wire

@@ design/sobel_et_mag.sv @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: magnitude stage
// Squares both gradients, sums them and compares against the edge limit.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_et_mag
  import sobel_et_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [GRAD_W-1:0] gx_i,
  input  wire logic signed [GRAD_W-1:0] gy_i,
  input  wire pos_t                     pos_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          edge_o,
  output pos_t                          pos_o
);

  // Gradient register
  logic                     v2_q, v2_d;
  logic signed [GRAD_W-1:0] gx2_q, gy2_q;
  pos_t                     pos2_q;
  // Square register
  logic                     v3_q, v3_d;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  pos_t                     pos3_q;
  // Output register
  logic                     vo_q, vo_d;
  logic                     edge_q;
  pos_t                     poso_q;

  logic                       rdy2, rdy3, rdyo;
  logic                       ld2, adv2, adv3;
  logic signed [2*GRAD_W-1:0] sqx_full, sqy_full;
  logic [MAG_W-1:0]           mag_sum;

  // Each stage frees when empty or when its successor takes the request
  assign rdyo = !vo_q || out_ready_i;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign ld2  = in_valid_i && rdy2;
  assign adv2 = v2_q && rdy3;
  assign adv3 = v3_q && rdyo;

  assign sqx_full = gx2_q * gx2_q;
  assign sqy_full = gy2_q * gy2_q;
  assign mag_sum  = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    v2_d = v2_q;
    if (ld2) begin
      v2_d = 1'b1;
    end else if (adv2) begin
      v2_d = 1'b0;
    end
    v3_d = v3_q;
    if (adv2) begin
      v3_d = 1'b1;
    end else if (adv3) begin
      v3_d = 1'b0;
    end
    vo_d = vo_q;
    if (adv3) begin
      vo_d = 1'b1;
    end else if (out_ready_i) begin
      vo_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v2_q <= v2_d;
      v3_q <= v3_d;
      vo_q <= vo_d;
    end
  end

  // Hold the gradients
  always_ff @(posedge clk_i) begin
    if (ld2) begin
      gx2_q  <= gx_i;
      gy2_q  <= gy_i;
      pos2_q <= pos_i;
    end
  end

  // Square both gradients; the squares are non-negative and fit SQ_W bits
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      sqx_q  <= sqx_full[SQ_W-1:0];
      sqy_q  <= sqy_full[SQ_W-1:0];
      pos3_q <= pos2_q;
    end
  end

  // Compare the magnitude against the limit
  always_ff @(posedge clk_i) begin
    if (adv3) begin
      edge_q <= mag_sum > MAG_W'(EDGE_LIMIT_SQ);
      poso_q <= pos3_q;
    end
  end

  assign in_ready_o  = rdy2;
  assign out_valid_o = vo_q;
  assign edge_o      = edge_q;
  assign pos_o       = poso_q;

endmodule

`default_nettype wire

@@ design/sobel_edge_threshold_top.sv @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: top level
// Streaming 3x3 Sobel edge detector with a thresholded magnitude per pixel.
// ----------------------------------------------------------------------------
//   Channel   Dir  Carries
//   pix_i     in   gray pixel, frame in raster order
//   res_o     out  edge flag, row, column, last mark of an interior pixel
//   APB       in   image_width at 0x0, image_height at 0x4
//
// Takes one pixel per clock unless stage 1 is stalled; the line store is read
// in the accept cycle and written through its separate write port when stage
// 1 moves on. A result passes stage 1 and the magnitude pipeline before it is
// valid on res_o. Border pixels produce no result; reset clears configuration,
// counters, valid flags and window, and the line stores need no clearing pass.
// A stalled result channel fills the magnitude pipeline before pix_i stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_threshold_top
  import sobel_et_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  sobel_et_pix_if.sink           pix_i,
  sobel_et_res_if.source         res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  // Configuration
  logic [DIM_W-1:0] width_q, height_q;
  logic [COL_W-1:0] wlast_q;
  logic [ROW_W-1:0] hlast_q;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0] wr_dim;

  // Position counters
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // Stage 1: accepted pixel waiting for its line store data
  logic             s1_v_q, s1_v_d;
  logic             s1_res_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_addr_q;
  pos_t             s1_pos_q;

  logic             in_acc, s1_adv;
  logic             mag_ready;
  logic [PIX_W-1:0] rd_up, rd_mid;
  logic [COL_W-1:0] col_m1;
  logic [ROW_W-1:0] row_m1;
  pos_t             pos_new;
  pix_col_t         win [3];
  pos_t             res_pos;
  logic             res_edge;

  logic [PIX_W+1:0]         sum_e, sum_w, sum_s, sum_n;
  logic signed [GRAD_W-1:0] gx, gy;

  // Decode register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[2 +: REG_IDX_W];
  assign wr_dim  = pwdata[DIM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
      wlast_q  <= COL_W'(MAX_WIDTH - 1);
      hlast_q  <= ROW_W'(MAX_HEIGHT - 1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH: begin
          width_q <= wr_dim;
          wlast_q <= COL_W'(clamp_dim(wr_dim, DIM_W'(MAX_WIDTH)) - DIM_W'(1));
        end
        REG_IMAGE_HEIGHT: begin
          height_q <= wr_dim;
          hlast_q  <= ROW_W'(clamp_dim(wr_dim, DIM_W'(MAX_HEIGHT)) - DIM_W'(1));
        end
        default: ;
      endcase
    end
  end

  // Return the raw register value
  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(height_q);
      default:          prdata = '0;
    endcase
  end

  // Accept a pixel whenever stage 1 is empty or moves on
  assign in_acc      = pix_i.valid && pix_i.ready;
  assign s1_adv      = s1_v_q && (!s1_res_q || mag_ready);
  assign pix_i.ready = !s1_v_q || s1_adv;

  // Advance the raster position, restart the frame on any register write
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (col_q == wlast_q) begin
        col_d = '0;
        row_d = (row_q == hlast_q) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Tag of the interior pixel one row up and one column left
  assign col_m1         = col_q - COL_W'(1);
  assign row_m1         = row_q - ROW_W'(1);
  assign pos_new.row    = row_m1[POS_W-1:0];
  assign pos_new.column = col_m1[POS_W-1:0];
  assign pos_new.last   = (row_q == hlast_q) && (col_q == wlast_q);

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_acc) begin
      s1_v_d = 1'b1;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= pix_i.pixel;
      s1_addr_q <= col_q;
      s1_res_q  <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
      s1_pos_q  <= pos_new;
    end
  end

  sobel_et_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_up_o   (rd_up),
    .rd_mid_o  (rd_mid),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_addr_q),
    .wr_up_i   (rd_mid),
    .wr_mid_i  (s1_pix_q)
  );

  // Newest column enters the row of window cells
  assign win[0].top = rd_up;
  assign win[0].mid = rd_mid;
  assign win[0].bot = s1_pix_q;

  for (genvar k = 0; k < 2; k++) begin : g_win
    sobel_et_win_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (cfg_wr),
      .shift_i (s1_adv),
      .col_i   (win[k]),
      .col_o   (win[k+1])
    );
  end

  // Sobel gradients: win[0] is column c, win[1] is c-1, win[2] is c-2
  assign sum_e = {2'b0, win[0].top} + {1'b0, win[0].mid, 1'b0} + {2'b0, win[0].bot};
  assign sum_w = {2'b0, win[2].top} + {1'b0, win[2].mid, 1'b0} + {2'b0, win[2].bot};
  assign sum_s = {2'b0, win[2].bot} + {1'b0, win[1].bot, 1'b0} + {2'b0, win[0].bot};
  assign sum_n = {2'b0, win[2].top} + {1'b0, win[1].top, 1'b0} + {2'b0, win[0].top};
  assign gx    = $signed({1'b0, sum_e}) - $signed({1'b0, sum_w});
  assign gy    = $signed({1'b0, sum_s}) - $signed({1'b0, sum_n});

  sobel_et_mag u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_v_q && s1_res_q),
    .in_ready_o  (mag_ready),
    .gx_i        (gx),
    .gy_i        (gy),
    .pos_i       (s1_pos_q),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .edge_o      (res_edge),
    .pos_o       (res_pos)
  );

  assign res_o.edge_res = res_edge;
  assign res_o.row      = res_pos.row;
  assign res_o.column   = res_pos.column;
  assign res_o.last     = res_pos.last;

endmodule

`default_nettype wire

@@ design/sobel_et_checker.sv @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: port checker
// Concurrent checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sobel_edge_threshold_top_assert.svh"

module sobel_et_checker
  import sobel_et_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic             out_edge_i,
  input wire logic [POS_W-1:0] out_row_i,
  input wire logic [POS_W-1:0] out_column_i,
  input wire logic             out_last_i,
  input wire logic             pready_i
);

  // A stalled result holds its payload
  `SOBEL_ET_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_edge_i) && $stable(out_row_i) && $stable(out_column_i) && $stable(out_last_i), "result changed while stalled")

  // Results only for interior pixels
  `SOBEL_ET_ASSERT_IMPLIES(a_res_interior, clk_i, rst_ni, out_valid_i, (out_row_i != '0) && (out_column_i != '0), "result on a border position")

  // Pixel side stalls only behind a stalled result
  `SOBEL_ET_ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i, "pixel stall without result backpressure")

  // Register port never waits
  `SOBEL_ET_ASSERT_IMPLIES(a_pready, clk_i, rst_ni, 1'b1, pready_i, "pready dropped")

endmodule

bind sobel_edge_threshold_top sobel_et_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (pix_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_edge_i   (res_o.edge_res),
  .out_row_i    (res_o.row),
  .out_column_i (res_o.column),
  .out_last_i   (res_o.last),
  .pready_i     (pready)
);

`default_nettype wire

@@ tb/sobel_edge_threshold_top_tb.sv @@
// ----------------------------------------------------------------------------
// Sobel edge threshold: testbench
// Streams gray frames of varied sizes into the edge detector and predicts
// every interior-pixel result in step with the accepted pixels. Each result
// is compared field by field with the oldest prediction. Frame sizes are
// set over APB only while the detector is idle, both channels idle and stall
// at random, and the stream may pause mid-frame until the output drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sobel_edge_threshold_top_tb;
  import sobel_et_pkg::*;

  localparam int RANDOM_ITEMS = 430;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_WAIT     = 18;

  // Pixel content styles of one stimulus phase
  typedef enum int {
    PIX_UNIFORM,
    PIX_BINARY,
    PIX_SMOOTH
  } pix_mode_e;

  // One predicted result
  typedef struct packed {
    logic             edge_res;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             last;
  } edge_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sobel_et_pix_if pix_if ();
  sobel_et_res_if res_if ();

  sobel_edge_threshold_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and prediction state
  logic [PIX_W-1:0] pixels_to_send [$];
  edge_result_t     pending_edges [$];
  int               mismatches = 0;
  bit               src_idle_on = 1'b1;
  bit               snk_idle_on = 1'b1;
  int unsigned      src_wait;
  int unsigned      snk_wait;

  logic [DIM_W-1:0] cfg_width  = DIM_W'(1024);
  logic [DIM_W-1:0] cfg_height = DIM_W'(1024);
  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [PIX_W-1:0] win_cols [3][2];
  int unsigned      row_cnt;
  int unsigned      col_cnt;

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Effective frame dimension after limiting to [3, maxv]
  function automatic int unsigned bounded_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void restart_frame_pred();
    row_cnt = 0;
    col_cnt = 0;
    for (int k = 0; k < 3; k++) begin
      win_cols[k][0] = '0;
      win_cols[k][1] = '0;
    end
  endfunction

  // Advance the window by one accepted pixel and queue its result, if any
  function automatic void predict_edge(logic [PIX_W-1:0] px);
    int unsigned      w, h, r, c, idx;
    int               nw, n, ne, wv, ev, sw, s, se, gx, gy, mag;
    logic [PIX_W-1:0] up, md;
    edge_result_t     res;
    w = bounded_dim(cfg_width, MAX_WIDTH);
    h = bounded_dim(cfg_height, MAX_HEIGHT);
    r = row_cnt;
    c = col_cnt;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    idx = c % MAX_WIDTH;
    up  = upper_line[idx];
    md  = middle_line[idx];
    if (r >= 2 && c >= 2) begin
      nw = win_cols[0][0];
      n  = win_cols[0][1];
      ne = up;
      wv = win_cols[1][0];
      ev = md;
      sw = win_cols[2][0];
      s  = win_cols[2][1];
      se = px;
      gx = (ne + 2 * ev + se) - (nw + 2 * wv + sw);
      gy = (sw + 2 * s + se) - (nw + 2 * n + ne);
      mag = gx * gx + gy * gy;
      res.edge_res = (mag > EDGE_LIMIT_SQ);
      res.row      = POS_W'(r - 1);
      res.column   = POS_W'(c - 1);
      res.last     = (r == h - 1) && (c == w - 1);
      pending_edges.push_back(res);
    end
    for (int k = 0; k < 3; k++) begin
      win_cols[k][0] = win_cols[k][1];
    end
    win_cols[0][1] = up;
    win_cols[1][1] = md;
    win_cols[2][1] = px;
    upper_line[idx]  = md;
    middle_line[idx] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_cnt = r;
    col_cnt = c;
  endfunction

  // Cycles to wait after a request: often none, else up to MAX_WAIT
  function automatic int unsigned draw_wait(bit idle_on);
    if (!idle_on || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [PIX_W-1:0] gen_pixel(pix_mode_e mode, logic [PIX_W-1:0] base);
    case (mode)
      PIX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_SMOOTH: return {base[7:4], 4'($urandom_range(0, 15))};
      default:    return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Pixel driver: hold each request until taken, then pause as drawn
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      pix_if.pixel <= '0;
      src_wait     <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        predict_edge(pix_if.pixel);
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (src_wait != 0) begin
          pix_if.valid <= 1'b0;
          src_wait     <= src_wait - 1;
        end else if (pixels_to_send.size() != 0) begin
          pix_if.valid <= 1'b1;
          pix_if.pixel <= pixels_to_send.pop_front();
          src_wait     <= draw_wait(src_idle_on);
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken request, then stall as drawn
  always @(posedge clk_i or negedge rst_ni) begin : res_monitor
    edge_result_t want;
    int unsigned  hold;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      snk_wait     <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_edges.size() == 0) begin
          $error("unexpected result: row %0d column %0d", res_if.row, res_if.column);
          mismatches++;
        end else begin
          want = pending_edges.pop_front();
          if (res_if.edge_res !== want.edge_res) begin
            $error("edge_res: expected %0d, actual %0d", want.edge_res, res_if.edge_res);
            mismatches++;
          end
          if (res_if.row !== want.row) begin
            $error("row: expected %0d, actual %0d", want.row, res_if.row);
            mismatches++;
          end
          if (res_if.column !== want.column) begin
            $error("column: expected %0d, actual %0d", want.column, res_if.column);
            mismatches++;
          end
          if (res_if.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, res_if.last);
            mismatches++;
          end
        end
      end
      if (snk_wait != 0) begin
        res_if.ready <= 1'b0;
        snk_wait     <= snk_wait - 1;
      end else if (res_if.valid && res_if.ready) begin
        hold = draw_wait(snk_idle_on);
        res_if.ready <= (hold == 0);
        snk_wait     <= (hold == 0) ? 0 : hold - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    // upper bits are don't-care for the 11-bit registers
    pwdata  <= ($urandom() & ~APB_DW'(32'h7FF)) | APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  cfg_width = val;
      REG_IMAGE_HEIGHT: cfg_height = val;
    endcase
    restart_frame_pred();
  endtask

  // Wait until every pixel is taken and every predicted result is seen
  task automatic drain();
    while (pixels_to_send.size() != 0 || pix_if.valid || pending_edges.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic idle_for_config();
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_pixels(int unsigned count, pix_mode_e mode, logic [PIX_W-1:0] base);
    @(negedge clk_i);
    repeat (count) pixels_to_send.push_back(gen_pixel(mode, base));
  endtask

  initial begin : stimulus
    int unsigned      sent;
    int unsigned      n;
    int unsigned      split;
    int unsigned      which;
    bit               first;
    pix_mode_e        mode;
    logic [PIX_W-1:0] base;
    logic [DIM_W-1:0] wval;
    logic [DIM_W-1:0] hval;
    logic [PIX_W-1:0] px;

    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    restart_frame_pred();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: 3x3 frames below the minimum size; a full-scale step,
    // then magnitudes exactly at and just above the threshold
    write_reg(REG_IMAGE_WIDTH, DIM_W'(0));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
    @(negedge clk_i);
    for (int f = 0; f < 3; f++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (c != 2) px = 8'd0;
          else if (f == 0) px = 8'd255;
          else if (f == 2 && r == 1) px = 8'd51;
          else px = 8'd50;
          pixels_to_send.push_back(px);
        end
      end
    end

    // Random small frames, partial frames and wraps
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      idle_for_config();
      which = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        0:       wval = DIM_W'($urandom_range(0, 2));
        1:       wval = DIM_W'(3);
        default: wval = DIM_W'($urandom_range(4, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       hval = DIM_W'($urandom_range(0, 2));
        1:       hval = $urandom_range(0, 1) ? DIM_W'(1024) : DIM_W'(2047);
        default: hval = DIM_W'($urandom_range(3, 8));
      endcase
      if (which != 1) write_reg(REG_IMAGE_WIDTH, wval);
      if (which != 0) write_reg(REG_IMAGE_HEIGHT, hval);
      mode        = pix_mode_e'($urandom_range(0, 2));
      base        = PIX_W'($urandom_range(0, 255));
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      n     = $urandom_range(8, 100);
      split = (first || $urandom_range(0, 3) == 0) ? n / 2 : n;
      queue_pixels(split, mode, base);
      // hold the stream mid-frame until the output has drained
      if (split < n) begin
        drain();
        queue_pixels(n - split, mode, base);
      end
      sent += n;
      first = 1'b0;
    end

    // Width above its range, minimum height
    idle_for_config();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    write_reg(REG_IMAGE_WIDTH, DIM_W'(2047));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
    queue_pixels(30, PIX_BINARY, '0);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
